[rtl/grfe_pkg.sv]
// ----------------------------------------------------------------------------
// grfe_pkg
// Shared codes, types and helpers for the grid rotate and flip engine.
// ----------------------------------------------------------------------------
package grfe_pkg;

    localparam int MAX_DIM_DEF = 64;

    // Field widths that the interface fixes.
    localparam int ACTION_W = 3;
    localparam int COORD_W  = 6;
    localparam int PIXEL_W  = 32;
    localparam int ANGLE_W  = 10;
    localparam int DIM_W    = 7;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_WRITE  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_ROTATE = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_MIRROR = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_FLIP   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ   = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    localparam int DEG_PER_TURN = 90;
    localparam int TURN_STEPS   = 12;

    typedef struct packed {
        logic wr;
        logic rd;
        logic rotate;
        logic mirror;
        logic flip;
    } cmd_t;

    // ceil(angle / 90) taken modulo four: count the thresholds that the angle passes.
    function automatic logic [1:0] turns_of_angle(input logic [ANGLE_W-1:0] angle);
        logic [3:0] cnt;
        cnt = '0;
        for (int k = 0; k < TURN_STEPS; k++) begin
            if (int'(angle) > k * DEG_PER_TURN) begin
                cnt = cnt + 4'd1;
            end
        end
        return cnt[1:0];
    endfunction

endpackage

[rtl/grfe_ctrl.sv]
// ----------------------------------------------------------------------------
// grfe_ctrl
// Handshake controller: decodes accepted words into datapath commands and
// tracks whether the result register holds a word.
// ----------------------------------------------------------------------------
module grfe_ctrl
    import grfe_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ACTION_W-1:0] action,
    output logic                out_valid,
    input  logic                out_ready,
    output cmd_t                cmd
);

    localparam logic ST_EMPTY = 1'b0;
    localparam logic ST_FULL  = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;

    // A new word may enter whenever the result register is free or is
    // being drained in this cycle.
    assign in_ready  = (state_reg == ST_EMPTY) || out_ready;
    assign out_valid = (state_reg == ST_FULL);
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        cmd = '0;
        if (accept)
        begin
            unique case (action)
                ACT_WRITE:  cmd.wr     = 1'b1;
                ACT_ROTATE: cmd.rotate = 1'b1;
                ACT_MIRROR: cmd.mirror = 1'b1;
                ACT_FLIP:   cmd.flip   = 1'b1;
                ACT_READ:   cmd.rd     = 1'b1;
                default:    cmd        = '0;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        if (cmd.rd)
        begin
            state_next = ST_FULL;
        end
        else if (out_ready)
        begin
            state_next = ST_EMPTY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cmd))
        else $error("more than one command issued");

    a_read_result: assert property (@(posedge clk) disable iff (!rst_n) cmd.rd |=> out_valid)
        else $error("read did not produce a result");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without a pending result");

endmodule

[rtl/grfe_datapath.sv]
// ----------------------------------------------------------------------------
// grfe_datapath
// Orientation state, size registers, address remapping, pixel memory and the
// result register.
// ----------------------------------------------------------------------------
module grfe_datapath
    import grfe_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmd_t                      cmd,
    input  logic [COORD_W-1:0]        row,
    input  logic [COORD_W-1:0]        col,
    input  logic signed [PIXEL_W-1:0] pixel_in,
    input  logic [ANGLE_W-1:0]        angle,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [DIM_W-1:0]          cfg_data,
    output logic signed [PIXEL_W-1:0] pixel_out,
    output logic [DIM_W-1:0]          cur_height,
    output logic [DIM_W-1:0]          cur_width
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [DIM_W-1:0] DIM_CAP =
        (MAX_DIM > 127) ? 7'd127 : DIM_W'(MAX_DIM);

    logic [DIM_W-1:0]   rows_reg;
    logic [DIM_W-1:0]   cols_reg;
    logic [1:0]         turns_reg;
    logic [1:0]         turns_next;
    logic               mirror_reg;
    logic               mirror_next;

    logic [DIM_W-1:0]   h;
    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   ch;
    logic [DIM_W-1:0]   cw;
    logic [DIM_W-1:0]   r_ext;
    logic [DIM_W-1:0]   c_ext;
    logic [DIM_W-1:0]   src_i;
    logic [DIM_W-1:0]   src_j;
    logic [DIM_W-1:0]   rot_j;
    logic               wr_inside;
    logic               rd_inside;
    logic [ADDR_W-1:0]  addr;

    logic [PIXEL_W-1:0] mem [DEPTH];
    logic [PIXEL_W-1:0] rd_data_reg;
    logic               inside_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [DIM_W-1:0]   width_reg;

    // A size of zero counts as one, and anything above the grid limit is clamped.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        if (v == '0)
        begin
            return 7'd1;
        end
        else if (v > DIM_CAP)
        begin
            return DIM_CAP;
        end
        return v;
    endfunction

    assign h     = eff_dim(rows_reg);
    assign w     = eff_dim(cols_reg);
    assign ch    = turns_reg[0] ? w : h;
    assign cw    = turns_reg[0] ? h : w;
    assign r_ext = DIM_W'(row);
    assign c_ext = DIM_W'(col);

    // Undo the rotation in closed form, then the mirror.
    always_comb
    begin
        unique case (turns_reg)
            2'd0:
            begin
                src_i = r_ext;
                rot_j = c_ext;
            end
            2'd1:
            begin
                src_i = h - 7'd1 - c_ext;
                rot_j = r_ext;
            end
            2'd2:
            begin
                src_i = h - 7'd1 - r_ext;
                rot_j = w - 7'd1 - c_ext;
            end
            default:
            begin
                src_i = c_ext;
                rot_j = w - 7'd1 - r_ext;
            end
        endcase
        src_j = mirror_reg ? (w - 7'd1 - rot_j) : rot_j;
    end

    assign wr_inside = (r_ext < h) && (c_ext < w);
    assign rd_inside = (r_ext < ch) && (c_ext < cw);

    always_comb
    begin
        if (cmd.rd)
        begin
            addr = ADDR_W'(ADDR_W'(src_i) * ADDR_W'(MAX_DIM)) + ADDR_W'(src_j);
        end
        else
        begin
            addr = ADDR_W'(ADDR_W'(r_ext) * ADDR_W'(MAX_DIM)) + ADDR_W'(c_ext);
        end
    end

    always_comb
    begin
        turns_next  = turns_reg;
        mirror_next = mirror_reg;
        if (cmd.rotate)
        begin
            turns_next = turns_reg + turns_of_angle(angle);
        end
        else if (cmd.mirror)
        begin
            turns_next  = 2'd0 - turns_reg;
            mirror_next = !mirror_reg;
        end
        else if (cmd.flip)
        begin
            turns_next  = 2'd2 - turns_reg;
            mirror_next = !mirror_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg   <= DIM_RESET;
            cols_reg   <= DIM_RESET;
            turns_reg  <= 2'd0;
            mirror_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_ROWS))
            begin
                rows_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == CFG_COLS))
            begin
                cols_reg <= cfg_data;
            end
            turns_reg  <= turns_next;
            mirror_reg <= mirror_next;
        end
    end

    // Single port memory with registered read data; the read register is the
    // result register and only changes when a read is taken.
    always_ff @(posedge clk)
    begin
        if (cmd.wr && wr_inside)
        begin
            mem[addr] <= pixel_in;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            inside_reg <= rd_inside;
            height_reg <= ch;
            width_reg  <= cw;
        end
    end

    assign pixel_out  = inside_reg ? $signed(rd_data_reg) : '0;
    assign cur_height = height_reg;
    assign cur_width  = width_reg;

    a_orient_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.rotate || cmd.mirror || cmd.flip) |=> ($stable(turns_reg) && $stable(mirror_reg)))
        else $error("orientation changed without a transform");

endmodule

[rtl/grid_rotate_flip_engine.sv]
// ----------------------------------------------------------------------------
// grid_rotate_flip_engine
// Pixel grid with quarter-turn rotation and mirroring applied on read.
// ----------------------------------------------------------------------------
// Writes, rotates, mirrors and flips may arrive every cycle unless a result
// waits on out_ready. A read goes through the single-port pixel memory, whose
// registered read data is the result register; the result word is valid the
// cycle after the read is accepted, and reads also run one per cycle as long
// as out_ready stays high. While a result waits, non-read and read words are
// held off only until it is taken. Transforms never move pixels: they update
// a two-bit turn count and a mirror bit that remap each read address. The
// pixel memory is not cleared after reset; only pixels that were written may
// be read. Sizes are taken from the rows and cols registers at each access.
// ----------------------------------------------------------------------------
module grid_rotate_flip_engine
    import grfe_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [ACTION_W-1:0]       action,
    input  logic [COORD_W-1:0]        row,
    input  logic [COORD_W-1:0]        col,
    input  logic signed [PIXEL_W-1:0] pixel_in,
    input  logic [ANGLE_W-1:0]        angle,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [PIXEL_W-1:0] pixel_out,
    output logic [DIM_W-1:0]          cur_height,
    output logic [DIM_W-1:0]          cur_width,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [DIM_W-1:0]          cfg_data
);

    cmd_t cmd;

    grfe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    grfe_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .row        (row),
        .col        (col),
        .pixel_in   (pixel_in),
        .angle      (angle),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pixel_out  (pixel_out),
        .cur_height (cur_height),
        .cur_width  (cur_width)
    );

endmodule
